[design/cbs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and register indexes for the cubic Bezier sampler.
package cbs_pkg;

  // Run length and coordinate format.
  localparam int MAX_SAMPLES = 64;
  localparam int COORD_BITS  = 16;
  localparam int CNT_W       = 7;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);

  // t is unsigned with T_FRAC fraction bits; one extra bit holds t = 1 exactly.
  localparam int T_FRAC  = 16;
  localparam int T_W     = T_FRAC + 1;
  localparam int T_ONE   = 2 ** T_FRAC;
  localparam int RND_HALF = 2 ** (T_FRAC - 1);

  // Restoring divider for the step 2^(T_FRAC+1) / (2 * (n - 1)).
  localparam int DIV_STEPS = T_FRAC + 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Coefficient, Horner accumulator and product widths.
  localparam int CF_W = COORD_BITS + 4;
  localparam int HW   = COORD_BITS + 6;
  localparam int PW   = HW + T_W + 1;

  localparam int CRD_MAX = 2 ** (COORD_BITS - 1) - 1;
  localparam int CRD_MIN = -(2 ** (COORD_BITS - 1));

  // Configuration register map.
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 4;
  localparam int REG_SEL_W = $clog2(NUM_REGS);
  localparam logic [REG_SEL_W-1:0] REG_P0_X = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_P0_Y = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_P1_X = REG_SEL_W'(2);
  localparam logic [REG_SEL_W-1:0] REG_P1_Y = REG_SEL_W'(3);
  localparam logic [REG_SEL_W-1:0] REG_P2_X = REG_SEL_W'(4);
  localparam logic [REG_SEL_W-1:0] REG_P2_Y = REG_SEL_W'(5);
  localparam logic [REG_SEL_W-1:0] REG_P3_X = REG_SEL_W'(6);
  localparam logic [REG_SEL_W-1:0] REG_P3_Y = REG_SEL_W'(7);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CF_W-1:0]       coef_t;

  // Power-basis coefficients of one axis: ((a t + b) t + c) t + d.
  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } poly_t;

  // One sample on its way into the evaluation pipeline.
  typedef struct packed {
    logic [T_W-1:0]   t;
    logic [IDX_W-1:0] idx;
    logic             last;
  } smp_t;

  // Sample sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } seq_st_t;

endpackage

[design/cbs_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sampler: request, point and configuration.

interface cbs_req_if;
  logic                      valid;
  logic                      ready;
  logic [cbs_pkg::CNT_W-1:0] sample_count;

  modport source (output valid, output sample_count, input ready);
  modport sink   (input valid, input sample_count, output ready);
endinterface

interface cbs_pt_if;
  logic                      valid;
  logic                      ready;
  cbs_pkg::coord_t           point_x;
  cbs_pkg::coord_t           point_y;
  logic [cbs_pkg::IDX_W-1:0] sample_index;
  logic                      last_point;

  modport source (output valid, output point_x, output point_y, output sample_index,
                  output last_point, input ready);
  modport sink   (input valid, input point_x, input point_y, input sample_index,
                  input last_point, output ready);
endinterface

interface cbs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cbs_pkg::REG_IDX_W-1:0] index;
  logic [cbs_pkg::COORD_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/cbs_tgen.sv]
`timescale 1ns / 1ps
// Sample sequencer: divides out the t step of a run, then issues one t per cycle while adv is high.
module cbs_tgen (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [cbs_pkg::CNT_W-1:0] req_count,
  input  logic                      adv,
  output logic                      issue_valid,
  output cbs_pkg::smp_t             issue
);

  cbs_pkg::seq_st_t state;
  cbs_pkg::seq_st_t state_next;

  logic [cbs_pkg::IDX_W-1:0]     den;
  logic [cbs_pkg::IDX_W:0]       d2;
  logic [cbs_pkg::IDX_W:0]       rem;
  logic [cbs_pkg::DIV_STEPS-1:0] quo;
  logic [cbs_pkg::DCNT_W-1:0]    div_cnt;
  logic [cbs_pkg::T_W-1:0]       t;
  logic [cbs_pkg::IDX_W:0]       frac;
  logic [cbs_pkg::IDX_W-1:0]     idx;

  logic [cbs_pkg::CNT_W-1:0]   n_clamp;
  logic                        div_bit;
  logic [cbs_pkg::IDX_W+1:0]   rem_sh;
  logic                        div_ge;
  logic [cbs_pkg::IDX_W:0]     rem_new;
  logic [cbs_pkg::IDX_W+1:0]   frac_sum;
  logic                        frac_ge;
  logic [cbs_pkg::IDX_W:0]     frac_new;
  logic [cbs_pkg::T_W-1:0]     t_new;
  logic                        last_now;

  // Clamp the requested count into the supported range.
  always_comb begin
    n_clamp = req_count;
    if (req_count < cbs_pkg::CNT_W'(2)) begin
      n_clamp = cbs_pkg::CNT_W'(2);
    end else if (req_count > cbs_pkg::CNT_W'(cbs_pkg::MAX_SAMPLES)) begin
      n_clamp = cbs_pkg::CNT_W'(cbs_pkg::MAX_SAMPLES);
    end
  end

  // One restoring division step per cycle; the dividend is a single one bit.
  assign div_bit = (div_cnt == cbs_pkg::DCNT_W'(cbs_pkg::DIV_STEPS - 1));
  assign rem_sh  = {rem, div_bit};
  assign div_ge  = (rem_sh >= {1'b0, d2});
  assign rem_new = div_ge ? (cbs_pkg::IDX_W + 1)'(rem_sh - {1'b0, d2})
                          : rem_sh[cbs_pkg::IDX_W:0];

  // Walk t by quotient and remainder, carrying when the fraction wraps.
  assign frac_sum = {1'b0, frac} + {1'b0, rem};
  assign frac_ge  = (frac_sum >= {1'b0, d2});
  assign frac_new = frac_ge ? frac_sum[cbs_pkg::IDX_W:0] - d2 : frac_sum[cbs_pkg::IDX_W:0];
  assign t_new    = t + quo[cbs_pkg::T_W-1:0] + cbs_pkg::T_W'(frac_ge);
  assign last_now = (idx == den);

  assign issue = '{t: t, idx: idx, last: last_now};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    issue_valid = 1'b0;
    unique case (state)
      cbs_pkg::ST_IDLE: begin
        req_ready = !rst;
        if (req_valid) begin
          state_next = cbs_pkg::ST_DIV;
        end
      end
      cbs_pkg::ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = cbs_pkg::ST_RUN;
        end
      end
      cbs_pkg::ST_RUN: begin
        issue_valid = 1'b1;
        if (adv && last_now) begin
          state_next = cbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Divider and sample walk registers.
  always_ff @(posedge clk) begin
    if (state == cbs_pkg::ST_IDLE && req_valid) begin
      den     <= cbs_pkg::IDX_W'(n_clamp - cbs_pkg::CNT_W'(1));
      d2      <= {cbs_pkg::IDX_W'(n_clamp - cbs_pkg::CNT_W'(1)), 1'b0};
      rem     <= '0;
      quo     <= '0;
      div_cnt <= cbs_pkg::DCNT_W'(cbs_pkg::DIV_STEPS - 1);
    end else if (state == cbs_pkg::ST_DIV) begin
      rem     <= rem_new;
      quo     <= {quo[cbs_pkg::DIV_STEPS-2:0], div_ge};
      div_cnt <= div_cnt - cbs_pkg::DCNT_W'(1);
      if (div_cnt == '0) begin
        t    <= '0;
        frac <= {1'b0, den};
        idx  <= '0;
      end
    end else if (state == cbs_pkg::ST_RUN && adv) begin
      t    <= t_new;
      frac <= frac_new;
      idx  <= idx + cbs_pkg::IDX_W'(1);
    end
  end

  // The walk must land on t = 1 exactly at the last point.
  a_last_t_one: assert property (@(posedge clk) disable iff (rst)
    (issue_valid && issue.last) |-> (issue.t == cbs_pkg::T_W'(cbs_pkg::T_ONE)))
    else $error("last sample of a run does not have t = 1");

  // Every run starts at t = 0.
  a_first_t_zero: assert property (@(posedge clk) disable iff (rst)
    (issue_valid && issue.idx == '0) |-> (issue.t == '0))
    else $error("first sample of a run does not have t = 0");

  // The fractional accumulator stays below the divisor during a run.
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == cbs_pkg::ST_RUN) |-> (frac < d2 && rem < d2))
    else $error("t walk remainder out of range");

endmodule

[design/cbs_eval.sv]
`timescale 1ns / 1ps
// Seven-stage Horner pipeline evaluating both axes, with the output register as last stage.
module cbs_eval (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      issue_valid,
  input  cbs_pkg::smp_t             issue,
  input  cbs_pkg::poly_t            coef [2],
  input  logic                      out_ready,
  output logic                      adv,
  output logic                      out_valid,
  output cbs_pkg::coord_t           out_x,
  output cbs_pkg::coord_t           out_y,
  output logic [cbs_pkg::IDX_W-1:0] out_idx,
  output logic                      out_last
);

  localparam int NSTG = 7;

  logic [NSTG-1:0]            vld;
  cbs_pkg::smp_t              meta [NSTG];
  logic signed [cbs_pkg::PW-1:0] p1 [2];
  logic signed [cbs_pkg::HW-1:0] h2 [2];
  logic signed [cbs_pkg::PW-1:0] p3 [2];
  logic signed [cbs_pkg::HW-1:0] h4 [2];
  logic signed [cbs_pkg::PW-1:0] p5 [2];
  logic signed [cbs_pkg::HW-1:0] h6 [2];
  cbs_pkg::coord_t               pt [2];

  // Round a Q.16-scaled product half up back to integer (Q.0) coordinates.
  function automatic logic signed [cbs_pkg::HW-1:0] rnd(input logic signed [cbs_pkg::PW-1:0] p);
    logic signed [cbs_pkg::PW-1:0] s;
    s = p + cbs_pkg::PW'(cbs_pkg::RND_HALF);
    return s[cbs_pkg::T_FRAC+cbs_pkg::HW-1:cbs_pkg::T_FRAC];
  endfunction

  // Clamp to the coordinate range.
  function automatic cbs_pkg::coord_t sat(input logic signed [cbs_pkg::HW-1:0] h);
    cbs_pkg::coord_t r;
    if (h > cbs_pkg::HW'(cbs_pkg::CRD_MAX)) begin
      r = cbs_pkg::COORD_BITS'(cbs_pkg::CRD_MAX);
    end else if (h < cbs_pkg::HW'(cbs_pkg::CRD_MIN)) begin
      r = cbs_pkg::COORD_BITS'(cbs_pkg::CRD_MIN);
    end else begin
      r = h[cbs_pkg::COORD_BITS-1:0];
    end
    return r;
  endfunction

  // The whole pipeline moves when the output register is free or being read.
  assign adv = !vld[NSTG-1] || out_ready;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], issue_valid};
    end
  end

  // Sample tags follow their data.
  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= issue;
      for (int k = 1; k < NSTG; k++) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  // Horner steps: multiply, then round and add the next coefficient.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        p1[a] <= cbs_pkg::HW'(coef[a].a) * $signed({1'b0, issue.t});
        h2[a] <= rnd(p1[a]) + cbs_pkg::HW'(coef[a].b);
        p3[a] <= h2[a] * $signed({1'b0, meta[1].t});
        h4[a] <= rnd(p3[a]) + cbs_pkg::HW'(coef[a].c);
        p5[a] <= h4[a] * $signed({1'b0, meta[3].t});
        h6[a] <= rnd(p5[a]) + cbs_pkg::HW'(coef[a].d);
        pt[a] <= sat(h6[a]);
      end
    end
  end

  assign out_valid = vld[NSTG-1];
  assign out_x     = pt[0];
  assign out_y     = pt[1];
  assign out_idx   = meta[NSTG-1].idx;
  assign out_last  = meta[NSTG-1].last;

endmodule

[design/cubic_bezier_sampler.sv]
`timescale 1ns / 1ps
// Top level of the cubic Bezier sampler: control point registers, coefficients and pipeline.
// A request carries a sample count n (clamped to 2..64) and yields n points of the curve at
// t = i/(n-1), each with its index and a flag on the final one. After a request is taken the
// sequencer finds the t step in a bit-serial divider, then issues one sample per cycle into a
// 7-stage evaluation pipeline whenever that pipeline advances; it takes the next request once
// the last sample of a run is issued, while earlier points may still be in the pipeline.
// Back-pressure on the point channel stalls the whole pipeline. The user must see that
// control points are written through the configuration channel only while no run is in flight;
// the block does not enforce this. Writes reach the coefficients through a second register.
module cubic_bezier_sampler (
  input  logic       clk,
  input  logic       rst,
  cbs_cfg_if.sink    cfg,
  cbs_req_if.sink    samples,
  cbs_pt_if.source   points
);

  cbs_pkg::coord_t ctrl [cbs_pkg::NUM_REGS];
  cbs_pkg::poly_t  coef [2];
  cbs_pkg::poly_t  coef_next [2];

  logic          adv;
  logic          issue_valid;
  cbs_pkg::smp_t issue;

  // Power-basis conversion of one axis.
  function automatic cbs_pkg::poly_t to_poly(input cbs_pkg::coord_t q0, input cbs_pkg::coord_t q1,
                                             input cbs_pkg::coord_t q2, input cbs_pkg::coord_t q3);
    cbs_pkg::coef_t e0;
    cbs_pkg::coef_t e1;
    cbs_pkg::coef_t e2;
    cbs_pkg::coef_t e3;
    cbs_pkg::coef_t d12;
    cbs_pkg::coef_t d10;
    cbs_pkg::poly_t r;
    e0  = cbs_pkg::CF_W'(q0);
    e1  = cbs_pkg::CF_W'(q1);
    e2  = cbs_pkg::CF_W'(q2);
    e3  = cbs_pkg::CF_W'(q3);
    d12 = e1 - e2;
    d10 = e1 - e0;
    r.a = e3 - e0 + d12 + (d12 <<< 1);
    r.b = e0 + (e0 <<< 1) - (e1 <<< 2) - (e1 <<< 1) + e2 + (e2 <<< 1);
    r.c = d10 + (d10 <<< 1);
    r.d = e0;
    return r;
  endfunction

  // Configuration writes; indexes past the register map are dropped.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < cbs_pkg::NUM_REGS; k++) begin
        ctrl[k] <= '0;
      end
    end else if (cfg.valid && cfg.index < cbs_pkg::REG_IDX_W'(cbs_pkg::NUM_REGS)) begin
      ctrl[cfg.index[cbs_pkg::REG_SEL_W-1:0]] <= cfg.data;
    end
  end

  // Coefficients are rebuilt from the control points every cycle.
  always_comb begin
    coef_next[0] = to_poly(ctrl[cbs_pkg::REG_P0_X], ctrl[cbs_pkg::REG_P1_X],
                           ctrl[cbs_pkg::REG_P2_X], ctrl[cbs_pkg::REG_P3_X]);
    coef_next[1] = to_poly(ctrl[cbs_pkg::REG_P0_Y], ctrl[cbs_pkg::REG_P1_Y],
                           ctrl[cbs_pkg::REG_P2_Y], ctrl[cbs_pkg::REG_P3_Y]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= '0;
      coef[1] <= '0;
    end else begin
      coef[0] <= coef_next[0];
      coef[1] <= coef_next[1];
    end
  end

  // Sample sequencer.
  cbs_tgen u_tgen (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (samples.valid),
    .req_ready   (samples.ready),
    .req_count   (samples.sample_count),
    .adv         (adv),
    .issue_valid (issue_valid),
    .issue       (issue)
  );

  // Evaluation pipeline.
  cbs_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue       (issue),
    .coef        (coef),
    .out_ready   (points.ready),
    .adv         (adv),
    .out_valid   (points.valid),
    .out_x       (points.point_x),
    .out_y       (points.point_y),
    .out_idx     (points.sample_index),
    .out_last    (points.last_point)
  );

endmodule
